/* sv/upwind_velocity_predictor_unit_defines.svh */
// ---------------------------------------------------------------------------
// Upwind velocity predictor assertion macros
// Shared property forms for the checker attached to the top level.
// ---------------------------------------------------------------------------
`ifndef UPWIND_VELOCITY_PREDICTOR_UNIT_DEFINES_SVH
`define UPWIND_VELOCITY_PREDICTOR_UNIT_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define UPV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while reset is asserted
`define UPV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define UPV_ASSERT_RESET(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/upv_pkg.sv */
// ---------------------------------------------------------------------------
// Upwind velocity predictor package
// Widths, coefficient defaults, register indexes, shared types and the
// fixed-point rounding and clipping helpers.
// ---------------------------------------------------------------------------
package upv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 20;
    localparam int IDX_W     = 3;

    // widest product (Courant factor times one-sided difference)
    localparam int PROD_W = 2 * DATA_W + 1;
    // rounded terms and their sum
    localparam int ACC_W  = PROD_W + 2 - FRAC_BITS;

    localparam int CRN_W  = DATA_W + COEF_W + 1;      // vel * adv coef
    localparam int DIF_W  = DATA_W + 1;               // two-point difference
    localparam int LAP_W  = DATA_W + 3;               // three-point laplacian
    localparam int GP_W   = DIF_W + COEF_W + 1;       // pressure diff * coef
    localparam int LP_W   = LAP_W + COEF_W + 1;       // laplacian * coef

    localparam logic [COEF_W-1:0] ADV_RST  = COEF_W'(16777);
    localparam logic [COEF_W-1:0] GRAD_RST = COEF_W'(8389);
    localparam logic [COEF_W-1:0] DIFF_RST = COEF_W'(4295);

    localparam logic signed [PROD_W-1:0] RND_HALF =
        {{(PROD_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_S32_MAX =
        {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_S32_MIN =
        {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_ADV_X  = 3'd0,
        REG_ADV_Y  = 3'd1,
        REG_GRAD_X = 3'd2,
        REG_GRAD_Y = 3'd3,
        REG_DIFF_X = 3'd4,
        REG_DIFF_Y = 3'd5
    } upv_reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] adv_x;
        logic [COEF_W-1:0] adv_y;
        logic [COEF_W-1:0] grad_x;
        logic [COEF_W-1:0] grad_y;
        logic [COEF_W-1:0] diff_x;
        logic [COEF_W-1:0] diff_y;
    } upv_coef_t;

    // hand-over from the front half to the back half
    typedef struct packed {
        logic signed [DATA_W-1:0] q;
        logic signed [DATA_W-1:0] cx;
        logic signed [DATA_W-1:0] cy;
        logic signed [DIF_W-1:0]  dx;
        logic signed [DIF_W-1:0]  dy;
        logic signed [ACC_W-1:0]  grad;
        logic signed [ACC_W-1:0]  lap_x;
        logic signed [ACC_W-1:0]  lap_y;
        logic                     sat;
    } upv_mid_t;

    typedef struct packed {
        logic              clipped;
        logic [DATA_W-1:0] value;
    } upv_clip_t;

    // rescale by FRAC_BITS, round to nearest, ties toward plus infinity
    function automatic logic signed [ACC_W-1:0] upv_round(
        input logic signed [PROD_W-1:0] x
    );
        logic signed [PROD_W-1:0] t;
        t = x + RND_HALF;
        t = t >>> FRAC_BITS;
        return t[ACC_W-1:0];
    endfunction

    function automatic upv_clip_t upv_clip32(input logic signed [ACC_W-1:0] x);
        upv_clip_t r;
        if (x > ACC_S32_MAX) begin
            r.clipped = 1'b1;
            r.value   = ACC_S32_MAX[DATA_W-1:0];
        end else if (x < ACC_S32_MIN) begin
            r.clipped = 1'b1;
            r.value   = ACC_S32_MIN[DATA_W-1:0];
        end else begin
            r.clipped = 1'b0;
            r.value   = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/upv_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Upwind velocity predictor coefficient registers
// Six 20-bit coefficients written through a write channel that never stalls.
// ---------------------------------------------------------------------------
module upv_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [upv_pkg::IDX_W-1:0]  cfg_index,
    input  logic [upv_pkg::COEF_W-1:0] cfg_data,
    output upv_pkg::upv_coef_t         coef
);
    import upv_pkg::*;

    upv_coef_t coef_reg;
    upv_coef_t coef_next;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_comb begin
        coef_next = coef_reg;
        if (cfg_valid) begin
            case (upv_reg_idx_t'(cfg_index))
                REG_ADV_X:  coef_next.adv_x  = cfg_data;
                REG_ADV_Y:  coef_next.adv_y  = cfg_data;
                REG_GRAD_X: coef_next.grad_x = cfg_data;
                REG_GRAD_Y: coef_next.grad_y = cfg_data;
                REG_DIFF_X: coef_next.diff_x = cfg_data;
                REG_DIFF_Y: coef_next.diff_y = cfg_data;
                default:    coef_next = coef_reg; // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.adv_x  <= ADV_RST;
            coef_reg.adv_y  <= ADV_RST;
            coef_reg.grad_x <= GRAD_RST;
            coef_reg.grad_y <= GRAD_RST;
            coef_reg.diff_x <= DIFF_RST;
            coef_reg.diff_y <= DIFF_RST;
        end else begin
            coef_reg <= coef_next;
        end
    end

endmodule

/* sv/upv_front.sv */
// ---------------------------------------------------------------------------
// Upwind velocity predictor front half
// Stage 1 differences and upwind selection, stage 2 coefficient products,
// stage 3 rounding and Courant factor clipping.
// ---------------------------------------------------------------------------
module upv_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  upv_pkg::upv_coef_t                coef,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_centre,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_west,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_east,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_south,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_north,
    input  logic signed [upv_pkg::DATA_W-1:0] s_vel_x,
    input  logic signed [upv_pkg::DATA_W-1:0] s_vel_y,
    input  logic signed [upv_pkg::DATA_W-1:0] s_pressure_plus,
    input  logic signed [upv_pkg::DATA_W-1:0] s_pressure_minus,
    output logic                              mid_valid,
    input  logic                              mid_ready,
    output upv_pkg::upv_mid_t                 mid
);
    import upv_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // stage 1
    logic                     func1_reg;
    logic signed [DATA_W-1:0] q1_reg, vx1_reg, vy1_reg;
    logic signed [DIF_W-1:0]  dp1_reg, dx1_reg, dy1_reg;
    logic signed [LAP_W-1:0]  lx1_reg, ly1_reg;
    logic signed [DIF_W-1:0]  dp1_next, dx1_next, dy1_next;
    logic signed [LAP_W-1:0]  lx1_next, ly1_next;

    // stage 2
    logic signed [DATA_W-1:0] q2_reg;
    logic signed [DIF_W-1:0]  dx2_reg, dy2_reg;
    logic signed [CRN_W-1:0]  cx2_reg, cy2_reg;
    logic signed [GP_W-1:0]   gp2_reg;
    logic signed [LP_W-1:0]   lx2_reg, ly2_reg;
    logic signed [CRN_W-1:0]  cx2_next, cy2_next;
    logic signed [GP_W-1:0]   gp2_next;
    logic signed [LP_W-1:0]   lx2_next, ly2_next;
    logic [COEF_W-1:0]        gcoef;

    // stage 3
    upv_mid_t  mid_reg;
    upv_mid_t  mid_next;
    upv_clip_t cx_clip, cy_clip;

    assign rdy3      = !v3_reg || mid_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign s_ready   = rdy1;
    assign mid_valid = v3_reg;
    assign mid       = mid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // zero velocity takes the west / south side
    always_comb begin
        dp1_next = DIF_W'(s_pressure_plus) - DIF_W'(s_pressure_minus);
        dx1_next = s_vel_x[DATA_W-1] ? (DIF_W'(s_q_centre) - DIF_W'(s_q_east))
                                     : (DIF_W'(s_q_west) - DIF_W'(s_q_centre));
        dy1_next = s_vel_y[DATA_W-1] ? (DIF_W'(s_q_centre) - DIF_W'(s_q_north))
                                     : (DIF_W'(s_q_south) - DIF_W'(s_q_centre));
        lx1_next = LAP_W'(s_q_west) + LAP_W'(s_q_east) - (LAP_W'(s_q_centre) <<< 1);
        ly1_next = LAP_W'(s_q_south) + LAP_W'(s_q_north) - (LAP_W'(s_q_centre) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            func1_reg <= s_func;
            q1_reg    <= s_q_centre;
            vx1_reg   <= s_vel_x;
            vy1_reg   <= s_vel_y;
            dp1_reg   <= dp1_next;
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            lx1_reg   <= lx1_next;
            ly1_reg   <= ly1_next;
        end
    end

    always_comb begin
        gcoef    = func1_reg ? coef.grad_y : coef.grad_x;
        cx2_next = CRN_W'(vx1_reg) * CRN_W'($signed({1'b0, coef.adv_x}));
        cy2_next = CRN_W'(vy1_reg) * CRN_W'($signed({1'b0, coef.adv_y}));
        gp2_next = GP_W'(dp1_reg) * GP_W'($signed({1'b0, gcoef}));
        lx2_next = LP_W'(lx1_reg) * LP_W'($signed({1'b0, coef.diff_x}));
        ly2_next = LP_W'(ly1_reg) * LP_W'($signed({1'b0, coef.diff_y}));
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            q2_reg  <= q1_reg;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            cx2_reg <= cx2_next;
            cy2_reg <= cy2_next;
            gp2_reg <= gp2_next;
            lx2_reg <= lx2_next;
            ly2_reg <= ly2_next;
        end
    end

    always_comb begin
        cx_clip        = upv_clip32(upv_round(PROD_W'(cx2_reg)));
        cy_clip        = upv_clip32(upv_round(PROD_W'(cy2_reg)));
        mid_next.q     = q2_reg;
        mid_next.cx    = $signed(cx_clip.value);
        mid_next.cy    = $signed(cy_clip.value);
        mid_next.dx    = dx2_reg;
        mid_next.dy    = dy2_reg;
        mid_next.grad  = upv_round(PROD_W'(gp2_reg));
        mid_next.lap_x = upv_round(PROD_W'(lx2_reg));
        mid_next.lap_y = upv_round(PROD_W'(ly2_reg));
        mid_next.sat   = cx_clip.clipped | cy_clip.clipped;
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            mid_reg <= mid_next;
        end
    end

endmodule

/* sv/upv_back.sv */
// ---------------------------------------------------------------------------
// Upwind velocity predictor back half
// Stage 4 advection products and partial sum, stage 5 rounding and final
// sum, stage 6 output saturation into the result register.
// ---------------------------------------------------------------------------
module upv_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              mid_valid,
    output logic                              mid_ready,
    input  upv_pkg::upv_mid_t                 mid,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [upv_pkg::DATA_W-1:0] m_new_value,
    output logic                              m_saturated
);
    import upv_pkg::*;

    logic v4_reg, v5_reg, v6_reg;
    logic rdy4, rdy5, rdy6;

    logic signed [PROD_W-1:0] px4_reg, py4_reg, px4_next, py4_next;
    logic signed [ACC_W-1:0]  part4_reg, part4_next;
    logic                     sat4_reg;

    logic signed [ACC_W-1:0]  sum5_reg, sum5_next;
    logic                     sat5_reg;

    logic signed [DATA_W-1:0] value6_reg;
    logic                     sat6_reg;
    upv_clip_t                out_clip;

    assign rdy6        = !v6_reg || m_ready;
    assign rdy5        = !v5_reg || rdy6;
    assign rdy4        = !v4_reg || rdy5;
    assign mid_ready   = rdy4;
    assign m_valid     = v6_reg;
    assign m_new_value = value6_reg;
    assign m_saturated = sat6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy4) v4_reg <= mid_valid;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_comb begin
        px4_next   = PROD_W'(mid.cx) * PROD_W'(mid.dx);
        py4_next   = PROD_W'(mid.cy) * PROD_W'(mid.dy);
        part4_next = ACC_W'(mid.q) - mid.grad + mid.lap_x + mid.lap_y;
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && mid_valid) begin
            px4_reg   <= px4_next;
            py4_reg   <= py4_next;
            part4_reg <= part4_next;
            sat4_reg  <= mid.sat;
        end
    end

    assign sum5_next = part4_reg + upv_round(px4_reg) + upv_round(py4_reg);

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            sum5_reg <= sum5_next;
            sat5_reg <= sat4_reg;
        end
    end

    assign out_clip = upv_clip32(sum5_reg);

    always_ff @(posedge aclk) begin
        if (rdy6 && v5_reg) begin
            value6_reg <= $signed(out_clip.value);
            sat6_reg   <= sat5_reg | out_clip.clipped;
        end
    end

endmodule

/* sv/upwind_velocity_predictor_unit.sv */
// Throughput: one transaction per cycle unless m_ready holds the output; each
// of the six stages holds on its own when the next is full, so bubbles close
// up and input keeps flowing while a result waits, until all six stages are
// full. Coefficient writes are registered and cfg_ready is always high.
// Reset (aresetn low, synchronous) empties all stages and restores defaults.
// ---------------------------------------------------------------------------
// Upwind velocity predictor
// Explicit upwind advection-diffusion update of one velocity component in
// signed fixed point, with saturation of the result.
// ---------------------------------------------------------------------------
module upwind_velocity_predictor_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [upv_pkg::IDX_W-1:0]         cfg_index,
    input  logic [upv_pkg::COEF_W-1:0]        cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_centre,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_west,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_east,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_south,
    input  logic signed [upv_pkg::DATA_W-1:0] s_q_north,
    input  logic signed [upv_pkg::DATA_W-1:0] s_vel_x,
    input  logic signed [upv_pkg::DATA_W-1:0] s_vel_y,
    input  logic signed [upv_pkg::DATA_W-1:0] s_pressure_plus,
    input  logic signed [upv_pkg::DATA_W-1:0] s_pressure_minus,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [upv_pkg::DATA_W-1:0] m_new_value,
    output logic                              m_saturated
);
    import upv_pkg::*;

    upv_coef_t coef;
    upv_mid_t  mid;
    logic      mid_valid;
    logic      mid_ready;

    upv_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    upv_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .coef             (coef),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_q_centre       (s_q_centre),
        .s_q_west         (s_q_west),
        .s_q_east         (s_q_east),
        .s_q_south        (s_q_south),
        .s_q_north        (s_q_north),
        .s_vel_x          (s_vel_x),
        .s_vel_y          (s_vel_y),
        .s_pressure_plus  (s_pressure_plus),
        .s_pressure_minus (s_pressure_minus),
        .mid_valid        (mid_valid),
        .mid_ready        (mid_ready),
        .mid              (mid)
    );

    upv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mid_valid   (mid_valid),
        .mid_ready   (mid_ready),
        .mid         (mid),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_value (m_new_value),
        .m_saturated (m_saturated)
    );

endmodule

/* sv/upv_checker.sv */
// ---------------------------------------------------------------------------
// Upwind velocity predictor port checker
// Watches the top-level ports for flow-control and reset behaviour.
// ---------------------------------------------------------------------------
`include "upwind_velocity_predictor_unit_defines.svh"

module upv_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [upv_pkg::DATA_W-1:0] m_new_value,
    input logic                              m_saturated
);
    import upv_pkg::*;

    // a stalled result holds
    `UPV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_new_value) && $stable(m_saturated), "result changed while stalled")

    // a draining output frees every stage, so the input side must be open
    `UPV_ASSERT_NOW(a_ready_chain, aclk, aresetn, m_ready, s_ready, "input blocked while output drains")

    // coefficient writes never stall
    `UPV_ASSERT_NOW(a_cfg_open, aclk, aresetn, cfg_valid, cfg_ready, "coefficient write stalled")

    // reset empties the pipeline
    `UPV_ASSERT_RESET(a_reset_empty, aclk, !aresetn, !m_valid, "result valid after reset")

endmodule

bind upwind_velocity_predictor_unit upv_checker u_upv_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Upwind velocity predictor testbench
// Drives stencil transactions and coefficient writes into the predictor,
// computes each expected update alongside it and compares every returned
// transaction in order, with random idle and stall bursts on both channels.
// ---------------------------------------------------------------------------
module tb_top;
    import upv_pkg::*;

    localparam int WIDE = 96;
    typedef logic signed [WIDE-1:0] wide_t;

    localparam wide_t S32_HI = wide_t'(2147483647);
    localparam wide_t S32_LO = -S32_HI - 1;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic [COEF_W-1:0]        COEF_MAX = 20'hFFFFF;
    localparam logic [COEF_W-1:0]        COEF_HALF = 20'h08000;

    // indexes with no register behind them
    localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct {
        logic                     func;
        logic signed [DATA_W-1:0] qc, qw, qe, qs, qn;
        logic signed [DATA_W-1:0] vx, vy;
        logic signed [DATA_W-1:0] pp, pm;
    } stencil_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } update_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index;
    logic [COEF_W-1:0]        cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_func;
    logic signed [DATA_W-1:0] s_q_centre, s_q_west, s_q_east, s_q_south, s_q_north;
    logic signed [DATA_W-1:0] s_vel_x, s_vel_y;
    logic signed [DATA_W-1:0] s_pressure_plus, s_pressure_minus;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_new_value;
    logic                     m_saturated;

    logic [COEF_W-1:0] coef_q [0:5];
    update_t           pending_updates [$];
    int                mismatch_count;
    bit                idling_on;
    int                gap_pct;
    int                stall_pct;

    upwind_velocity_predictor_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_q_centre       (s_q_centre),
        .s_q_west         (s_q_west),
        .s_q_east         (s_q_east),
        .s_q_south        (s_q_south),
        .s_q_north        (s_q_north),
        .s_vel_x          (s_vel_x),
        .s_vel_y          (s_vel_y),
        .s_pressure_plus  (s_pressure_plus),
        .s_pressure_minus (s_pressure_minus),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_new_value      (m_new_value),
        .m_saturated      (m_saturated)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ---------------- prediction ----------------

    // rescale by the fraction bits, nearest, ties toward plus infinity
    function automatic wide_t rescale(input wide_t x);
        return (x + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic wide_t clamp32(input wide_t x, inout logic hit);
        if (x > S32_HI) begin
            hit = 1'b1;
            return S32_HI;
        end
        if (x < S32_LO) begin
            hit = 1'b1;
            return S32_LO;
        end
        return x;
    endfunction

    function automatic wide_t upwind_term(input logic signed [DATA_W-1:0] vel,
                                          input logic [COEF_W-1:0] coef,
                                          input wide_t q, input wide_t q_minus,
                                          input wide_t q_plus, inout logic hit);
        wide_t v, k, courant, d;
        v = wide_t'(vel);
        k = wide_t'(coef);
        courant = clamp32(rescale(v * k), hit);
        // zero velocity takes the minus-side difference
        d = (v >= 0) ? q_minus - q : q - q_plus;
        return rescale(courant * d);
    endfunction

    function automatic update_t predict_update(input stencil_t st);
        update_t r;
        wide_t   q, qw, qe, qs, qn, pp, pm, g, kx, ky, acc, adv_x, adv_y;
        logic    hit;
        hit = 1'b0;
        q  = wide_t'(st.qc);
        qw = wide_t'(st.qw);
        qe = wide_t'(st.qe);
        qs = wide_t'(st.qs);
        qn = wide_t'(st.qn);
        pp = wide_t'(st.pp);
        pm = wide_t'(st.pm);
        g  = st.func ? wide_t'(coef_q[REG_GRAD_Y]) : wide_t'(coef_q[REG_GRAD_X]);
        kx = wide_t'(coef_q[REG_DIFF_X]);
        ky = wide_t'(coef_q[REG_DIFF_Y]);
        adv_x = upwind_term(st.vx, coef_q[REG_ADV_X], q, qw, qe, hit);
        adv_y = upwind_term(st.vy, coef_q[REG_ADV_Y], q, qs, qn, hit);
        acc = q - rescale((pp - pm) * g) + adv_x + adv_y
              + rescale((qw - 2 * q + qe) * kx)
              + rescale((qs - 2 * q + qn) * ky);
        acc = clamp32(acc, hit);
        r.value = acc[DATA_W-1:0];
        r.sat   = hit;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic stencil_t make_stencil(
        input logic f,
        input logic signed [DATA_W-1:0] c, w, e, s, n, vx, vy, pp, pm
    );
        stencil_t st;
        st.func = f;
        st.qc = c;
        st.qw = w;
        st.qe = e;
        st.qs = s;
        st.qn = n;
        st.vx = vx;
        st.vy = vy;
        st.pp = pp;
        st.pm = pm;
        return st;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        int t;
        case ($urandom_range(0, 11))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4, 5, 6: begin
                t = $urandom_range(0, 1 << 21);
                return t - (1 << 20);
            end
            7, 8: begin
                t = $urandom_range(0, 1 << 27);
                return t - (1 << 26);
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic stencil_t rand_stencil();
        return make_stencil(1'($urandom_range(0, 1)), rand_word(), rand_word(), rand_word(),
                            rand_word(), rand_word(), rand_word(), rand_word(),
                            rand_word(), rand_word());
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COEF_MAX;
            2, 3: return COEF_W'($urandom_range(0, 1 << 16));
            4, 5: return COEF_W'($urandom_range(0, 1 << 13));
            default: return COEF_W'($urandom);
        endcase
    endfunction

    task automatic send_stencil(input stencil_t st);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 18);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid          <= 1'b1;
        s_func           <= st.func;
        s_q_centre       <= st.qc;
        s_q_west         <= st.qw;
        s_q_east         <= st.qe;
        s_q_south        <= st.qs;
        s_q_north        <= st.qn;
        s_vel_x          <= st.vx;
        s_vel_y          <= st.vy;
        s_pressure_plus  <= st.pp;
        s_pressure_minus <= st.pm;
        do @(posedge aclk); while (!s_ready);
        pending_updates.push_back(predict_update(st));
    endtask

    // stop sending and let the pipeline empty
    task automatic settle();
        int guard;
        @(negedge aclk);
        s_valid <= 1'b0;
        guard = 0;
        while (pending_updates.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= REG_DIFF_Y)
            coef_q[idx] = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_coefs(input logic [COEF_W-1:0] ax, ay, gx, gy, dx, dy);
        settle();
        write_coef(REG_ADV_X, ax);
        write_coef(REG_ADV_Y, ay);
        write_coef(REG_GRAD_X, gx);
        write_coef(REG_GRAD_Y, gy);
        write_coef(REG_DIFF_X, dx);
        write_coef(REG_DIFF_Y, dy);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_stencil(rand_stencil());
    endtask

    // ---------------- result channel ----------------

    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idling_on && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n - 1) @(negedge aclk);
                @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what, input update_t expd);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected value %0d sat %0b, got value %0d sat %0b",
                     $realtime, what, expd.value, expd.sat, m_new_value, m_saturated);
    endtask

    always @(posedge aclk) begin
        update_t expd;
        if (aresetn && m_valid && m_ready) begin
            if (pending_updates.size() == 0) begin
                expd.value = 'x;
                expd.sat   = 1'bx;
                report_mismatch("unexpected transaction", expd);
            end else begin
                expd = pending_updates.pop_front();
                if (m_new_value !== expd.value)
                    report_mismatch("new_value differs", expd);
                else if (m_saturated !== expd.sat)
                    report_mismatch("saturated differs", expd);
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_default_coefs();
        send_stencil(make_stencil(1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_stencil(make_stencil(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_stencil(make_stencil(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                  Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_stencil(make_stencil(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                  Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        // zero velocities pick the west and south neighbours
        send_stencil(make_stencil(1'b0, Q_ONE, 3 * Q_ONE, -5 * Q_ONE, 7 * Q_ONE,
                                  -2 * Q_ONE, '0, '0, Q_ONE, -Q_ONE));
        send_stencil(make_stencil(1'b1, Q_ONE, 3 * Q_ONE, -5 * Q_ONE, 7 * Q_ONE,
                                  -2 * Q_ONE, -Q_ONE, -2 * Q_ONE, -Q_ONE, Q_ONE));
        send_stencil(make_stencil(1'b0, 2 * Q_ONE, Q_ONE, 4 * Q_ONE, -Q_ONE,
                                  Q_ONE / 2, Q_ONE, 3 * Q_ONE, 5 * Q_ONE, 2 * Q_ONE));
        send_stencil(make_stencil(1'b1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                                  Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    endtask

    task automatic test_saturation();
        set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        // Courant factor clips on both axes
        send_stencil(make_stencil(1'b0, '0, Q_ONE, '0, Q_ONE, '0, Q_MAX, Q_MIN, '0, '0));
        send_stencil(make_stencil(1'b1, '0, '0, Q_ONE, '0, -Q_ONE, Q_MIN, Q_MAX, '0, '0));
        // sum runs past either end of the range
        send_stencil(make_stencil(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                  '0, '0, Q_MIN, Q_MAX));
        send_stencil(make_stencil(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                  '0, '0, Q_MAX, Q_MIN));
        send_stencil(make_stencil(1'b0, '0, Q_MIN, Q_MAX, Q_MAX, Q_MIN,
                                  Q_MAX, Q_MAX, Q_MAX, Q_MIN));
    endtask

    task automatic test_rounding_ties();
        set_coefs('0, '0, COEF_HALF, '0, '0, '0);
        send_stencil(make_stencil(1'b0, Q_ONE, '0, '0, '0, '0, '0, '0, 32'sd1, '0));
        send_stencil(make_stencil(1'b0, Q_ONE, '0, '0, '0, '0, '0, '0, '0, 32'sd1));
        send_stencil(make_stencil(1'b0, Q_ONE, '0, '0, '0, '0, '0, '0, 32'sd3, '0));
        send_stencil(make_stencil(1'b1, Q_ONE, '0, '0, '0, '0, '0, '0, 32'sd3, '0));
    endtask

    task automatic test_spare_indexes();
        settle();
        write_coef(IDX_SPARE_LO, COEF_MAX);
        write_coef(IDX_SPARE_HI, rand_coef());
        send_stencil(make_stencil(1'b0, Q_ONE, 2 * Q_ONE, '0, '0, -Q_ONE,
                                  Q_ONE, -Q_ONE, 32'sd1, '0));
    endtask

    task automatic test_zero_coefs();
        set_coefs('0, '0, '0, '0, '0, '0);
        send_stencil(make_stencil(1'b1, -Q_ONE, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                  Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        send_random(10);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            set_coefs(rand_coef(), rand_coef(), rand_coef(),
                      rand_coef(), rand_coef(), rand_coef());
            if ($urandom_range(0, 3) == 0)
                write_coef(IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), rand_coef());
            gap_pct   = $urandom_range(0, 50);
            stall_pct = $urandom_range(0, 50);
            send_random(120);
        end
    endtask

    task automatic test_reset_values();
        set_coefs(ADV_RST, ADV_RST, GRAD_RST, GRAD_RST, DIFF_RST, DIFF_RST);
        gap_pct   = 25;
        stall_pct = 25;
        send_random(100);
    endtask

    task automatic test_full_rate();
        set_coefs(rand_coef(), rand_coef(), rand_coef(),
                  rand_coef(), rand_coef(), rand_coef());
        idling_on = 1'b0;
        send_random(250);
    endtask

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_func           = 1'b0;
        s_q_centre       = '0;
        s_q_west         = '0;
        s_q_east         = '0;
        s_q_south        = '0;
        s_q_north        = '0;
        s_vel_x          = '0;
        s_vel_y          = '0;
        s_pressure_plus  = '0;
        s_pressure_minus = '0;
        mismatch_count   = 0;
        idling_on        = 1'b1;
        gap_pct          = 20;
        stall_pct        = 20;
        coef_q[REG_ADV_X]  = ADV_RST;
        coef_q[REG_ADV_Y]  = ADV_RST;
        coef_q[REG_GRAD_X] = GRAD_RST;
        coef_q[REG_GRAD_Y] = GRAD_RST;
        coef_q[REG_DIFF_X] = DIFF_RST;
        coef_q[REG_DIFF_Y] = DIFF_RST;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_coefs();
        test_saturation();
        test_rounding_ties();
        test_spare_indexes();
        test_zero_coefs();
        test_random_settings();
        test_reset_values();
        test_full_rate();

        settle();
        if (pending_updates.size() != 0) begin
            $display("%0d transactions never arrived", pending_updates.size());
            mismatch_count += pending_updates.size();
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
